[rtl/hvsfm_pkg.sv]
// ----------------------------------------------------------------------------
// hvsfm_pkg
// Types and constants shared by the HV supply fault monitor.
// ----------------------------------------------------------------------------
package hvsfm_pkg;

	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_HV_ON  = 2'd1,
		MODE_HV_OFF = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_CURRENT_SETPOINT = 2'd0,
		CFG_VOLTAGE_SETPOINT = 2'd1,
		CFG_DEBUG_BYPASS     = 2'd2,
		CFG_NONE             = 2'd3
	} cfg_idx_t;

	localparam int SAMPLE_W = 10;
	localparam int COUNT_W  = 6;

	localparam logic [COUNT_W-1:0] WINDOW_DEBOUNCE_TICKS = COUNT_W'(50);
	localparam logic [COUNT_W-1:0] TEMP_DEBOUNCE_TICKS   = COUNT_W'(33);

	localparam int PCT_SCALE  = 100;
	localparam int CUR_HI_PCT = 118;
	localparam int CUR_LO_PCT = 82;
	localparam int VLT_HI_PCT = 109;
	localparam int VLT_LO_PCT = 91;

	localparam logic [SAMPLE_W-1:0] TEMP_SET_LIMIT = SAMPLE_W'(333);
	localparam logic [SAMPLE_W-1:0] TEMP_CLR_LIMIT = SAMPLE_W'(330);

	localparam logic [7:0] ALARM_MAX = 8'd200;

	localparam logic [7:0] FAULT_TEMP    = 8'h02;
	localparam logic [7:0] FAULT_HIGH_MA = 8'h08;
	localparam logic [7:0] FAULT_LOW_MA  = 8'h10;
	localparam logic [7:0] FAULT_LOW_KV  = 8'h20;
	localparam logic [7:0] FAULT_HIGH_KV = 8'h40;
	localparam logic [7:0] FAULT_TEMP_CLR_MASK = 8'hfd;

	typedef struct packed {
		logic [1:0]          mode;
		logic [SAMPLE_W-1:0] current_sample;
		logic [SAMPLE_W-1:0] voltage_sample;
		logic [SAMPLE_W-1:0] temp_sample;
	} item_t;

	typedef struct packed {
		logic       hv_enable;
		logic       xray_led;
		logic       oc_led;
		logic       uc_led;
		logic       ov_led;
		logic       uv_led;
		logic       ot_led;
		logic [7:0] fault_code;
		logic [7:0] alarm_count;
		logic       clear_open_count;
		logic       clear_xray_timers;
	} result_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] current_setpoint;
		logic [SAMPLE_W-1:0] voltage_setpoint;
		logic                debug_bypass;
	} cfg_regs_t;

endpackage

[rtl/hvsfm_item_if.sv]
// ----------------------------------------------------------------------------
// hvsfm_item_if
// Valid/ready channel carrying one monitor input item.
// ----------------------------------------------------------------------------
interface hvsfm_item_if;
	import hvsfm_pkg::*;

	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/hvsfm_result_if.sv]
// ----------------------------------------------------------------------------
// hvsfm_result_if
// Valid/ready channel carrying one monitor result item.
// ----------------------------------------------------------------------------
interface hvsfm_result_if;
	import hvsfm_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/hvsfm_cfg_if.sv]
// ----------------------------------------------------------------------------
// hvsfm_cfg_if
// Register write channel: index and write data under valid/ready.
// ----------------------------------------------------------------------------
interface hvsfm_cfg_if;
	import hvsfm_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          index;
	logic [SAMPLE_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/hv_supply_fault_monitor_unit.sv]
// ----------------------------------------------------------------------------
// hv_supply_fault_monitor_unit
// Protection monitor for a high-voltage supply: window, temperature and
// command handling with latched fault indicators.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one result. An item is registered on
// acceptance and its result is registered from it once the result stage can advance,
// and a new item is taken every cycle while the result side keeps up;
// the whole update is one pass of compares and counters over the item
// register. Setpoints and the bypass bit are written through cfg, always
// ready, and should only change while no item is in flight.
module hv_supply_fault_monitor_unit (
	input logic           clk,
	input logic           arst_n,
	hvsfm_item_if.sink    item,
	hvsfm_result_if.source result,
	hvsfm_cfg_if.sink     cfg
);
	import hvsfm_pkg::*;

	logic      valid_s1;
	item_t     item_s1;
	logic      res_valid_q;
	result_t   res_q;
	result_t   core_res;
	cfg_regs_t regs_q;
	logic      advance, step;

	assign advance    = !res_valid_q || result.ready;
	assign step       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= core_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_CURRENT_SETPOINT: regs_q.current_setpoint <= cfg.data;
				CFG_VOLTAGE_SETPOINT: regs_q.voltage_setpoint <= cfg.data;
				CFG_DEBUG_BYPASS:     regs_q.debug_bypass     <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	hvsfm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.regs   (regs_q),
		.res    (core_res)
	);

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	a_xray_clear_hv_off: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.clear_xray_timers |-> !result.data.hv_enable)
		else $error("x-ray timer clear with HV on");

	a_alarm_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.data.alarm_count <= ALARM_MAX)
		else $error("alarm count above saturation");

	a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> result.valid && !result.ready)
		else $error("input stalled without output backpressure");
endmodule

[rtl/hvsfm_core.sv]
// ----------------------------------------------------------------------------
// hvsfm_core
// Monitor state and single-pass update for one item.
// ----------------------------------------------------------------------------
module hvsfm_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  hvsfm_pkg::item_t     item,
	input  hvsfm_pkg::cfg_regs_t regs,
	output hvsfm_pkg::result_t   res
);
	import hvsfm_pkg::*;

	localparam int I_OC = 0;
	localparam int I_UC = 1;
	localparam int I_OV = 2;
	localparam int I_UV = 3;
	localparam int I_OT = 4;
	localparam int PROD_W = 17;

	typedef struct packed {
		logic [COUNT_W-1:0] cnt;
		logic               hit;
	} deb_t;

	function automatic deb_t debounce(input logic [COUNT_W-1:0] cnt, input logic cond,
	                                  input logic [COUNT_W-1:0] limit);
		deb_t               r;
		logic [COUNT_W-1:0] inc;
		inc = cnt + COUNT_W'(1);
		r.hit = 1'b0;
		r.cnt = '0;
		if (cond) begin
			if (inc >= limit) begin
				r.hit = 1'b1;
			end else begin
				r.cnt = inc;
			end
		end
		return r;
	endfunction

	logic               hv_on_q, xray_q;
	logic [COUNT_W-1:0] oc_cnt_q, uc_cnt_q, ov_cnt_q, uv_cnt_q, hot_cnt_q, cool_cnt_q;
	logic [3:0]         pend_q;
	logic [7:0]         alarm_q, fault_q;
	logic [4:0]         led_q;

	logic               hv_d, xray_d;
	logic [COUNT_W-1:0] oc_cnt_d, uc_cnt_d, ov_cnt_d, uv_cnt_d, hot_cnt_d, cool_cnt_d;
	logic [3:0]         pend_d;
	logic [7:0]         alarm_d, fault_d;
	logic [4:0]         led_d;
	logic               clr_open, clr_xray;

	logic [SAMPLE_W:0]  cur_p1, vlt_p1;
	logic               oc_cond, uc_cond, ov_cond, uv_cond;
	deb_t               oc_r, uc_r, ov_r, uv_r;
	logic [COUNT_W-1:0] hot_inc, cool_inc;

	assign cur_p1 = {1'b0, item.current_sample} + (SAMPLE_W+1)'(1);
	assign vlt_p1 = {1'b0, item.voltage_sample} + (SAMPLE_W+1)'(1);

	// x >= floor(p/100) <=> (x+1)*100 > p ; x <= floor(p/100) <=> x*100 <= p
	assign oc_cond = (PROD_W'(cur_p1) * PROD_W'(PCT_SCALE))
	                 > (PROD_W'(regs.current_setpoint) * PROD_W'(CUR_HI_PCT));
	assign uc_cond = (PROD_W'(item.current_sample) * PROD_W'(PCT_SCALE))
	                 <= (PROD_W'(regs.current_setpoint) * PROD_W'(CUR_LO_PCT));
	assign ov_cond = (PROD_W'(vlt_p1) * PROD_W'(PCT_SCALE))
	                 > (PROD_W'(regs.voltage_setpoint) * PROD_W'(VLT_HI_PCT));
	assign uv_cond = (PROD_W'(item.voltage_sample) * PROD_W'(PCT_SCALE))
	                 <= (PROD_W'(regs.voltage_setpoint) * PROD_W'(VLT_LO_PCT));

	assign oc_r = debounce(oc_cnt_q, oc_cond, WINDOW_DEBOUNCE_TICKS);
	assign uc_r = debounce(uc_cnt_q, uc_cond, WINDOW_DEBOUNCE_TICKS);
	assign ov_r = debounce(ov_cnt_q, ov_cond, WINDOW_DEBOUNCE_TICKS);
	assign uv_r = debounce(uv_cnt_q, uv_cond, WINDOW_DEBOUNCE_TICKS);

	assign hot_inc  = hot_cnt_q + COUNT_W'(1);
	assign cool_inc = cool_cnt_q + COUNT_W'(1);

	always_comb begin
		hv_d       = hv_on_q;
		xray_d     = xray_q;
		oc_cnt_d   = oc_cnt_q;
		uc_cnt_d   = uc_cnt_q;
		ov_cnt_d   = ov_cnt_q;
		uv_cnt_d   = uv_cnt_q;
		hot_cnt_d  = hot_cnt_q;
		cool_cnt_d = cool_cnt_q;
		pend_d     = pend_q;
		alarm_d    = alarm_q;
		fault_d    = fault_q;
		led_d      = led_q;
		clr_open   = 1'b0;
		clr_xray   = 1'b0;

		case (mode_t'(item.mode))
			MODE_TICK: begin
				if (|pend_q) begin
					alarm_d = (alarm_q >= ALARM_MAX - 8'd1) ? ALARM_MAX : alarm_q + 8'd1;
				end
				if (!regs.debug_bypass) begin
					if (hv_on_q) begin
						oc_cnt_d = oc_r.cnt;
						uc_cnt_d = uc_r.cnt;
						ov_cnt_d = ov_r.cnt;
						uv_cnt_d = uv_r.cnt;
						if (oc_r.hit || ov_r.hit || uv_r.hit) begin
							hv_d = 1'b0;
						end
						if (oc_r.hit) begin
							pend_d[I_OC] = ~pend_q[I_OC];
							if (pend_q[I_OC]) begin
								clr_open   = 1'b1;
								fault_d    = fault_d | FAULT_HIGH_MA;
								led_d[I_OC] = 1'b1;
							end
						end
						if (uc_r.hit) begin
							pend_d[I_UC] = ~pend_q[I_UC];
							if (pend_q[I_UC]) begin
								fault_d    = fault_d | FAULT_LOW_MA;
								led_d[I_UC] = 1'b1;
							end
						end
						if (ov_r.hit) begin
							pend_d[I_OV] = ~pend_q[I_OV];
							if (pend_q[I_OV]) begin
								clr_open   = 1'b1;
								fault_d    = fault_d | FAULT_HIGH_KV;
								led_d[I_OV] = 1'b1;
							end
						end
						if (uv_r.hit) begin
							pend_d[I_UV] = ~pend_q[I_UV];
							if (pend_q[I_UV]) begin
								clr_open   = 1'b1;
								fault_d    = fault_d | FAULT_LOW_KV;
								led_d[I_UV] = 1'b1;
							end
						end
					end else begin
						oc_cnt_d = '0;
						uc_cnt_d = '0;
						ov_cnt_d = '0;
						uv_cnt_d = '0;
					end
				end
				xray_d   = hv_d;
				clr_xray = ~hv_d;
				if (item.temp_sample >= TEMP_SET_LIMIT) begin
					if (hot_inc >= TEMP_DEBOUNCE_TICKS) begin
						hot_cnt_d   = '0;
						fault_d     = fault_d | FAULT_TEMP;
						led_d[I_OT] = 1'b1;
						hv_d        = 1'b0;
					end else begin
						hot_cnt_d = hot_inc;
					end
				end else if (item.temp_sample <= TEMP_CLR_LIMIT) begin
					if (cool_inc >= TEMP_DEBOUNCE_TICKS) begin
						cool_cnt_d  = '0;
						fault_d     = fault_d & FAULT_TEMP_CLR_MASK;
						led_d[I_OT] = 1'b0;
					end else begin
						cool_cnt_d = cool_inc;
					end
				end
			end
			MODE_HV_ON: begin
				hv_d = 1'b1;
			end
			MODE_HV_OFF: begin
				alarm_d  = '0;
				pend_d   = '0;
				clr_open = 1'b1;
				hv_d     = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_on_q    <= 1'b0;
			xray_q     <= 1'b0;
			oc_cnt_q   <= '0;
			uc_cnt_q   <= '0;
			ov_cnt_q   <= '0;
			uv_cnt_q   <= '0;
			hot_cnt_q  <= '0;
			cool_cnt_q <= '0;
			pend_q     <= '0;
			alarm_q    <= '0;
			fault_q    <= '0;
			led_q      <= '0;
		end else if (step) begin
			hv_on_q    <= hv_d;
			xray_q     <= xray_d;
			oc_cnt_q   <= oc_cnt_d;
			uc_cnt_q   <= uc_cnt_d;
			ov_cnt_q   <= ov_cnt_d;
			uv_cnt_q   <= uv_cnt_d;
			hot_cnt_q  <= hot_cnt_d;
			cool_cnt_q <= cool_cnt_d;
			pend_q     <= pend_d;
			alarm_q    <= alarm_d;
			fault_q    <= fault_d;
			led_q      <= led_d;
		end
	end

	always_comb begin
		res.hv_enable         = hv_d;
		res.xray_led          = xray_d;
		res.oc_led            = led_d[I_OC];
		res.uc_led            = led_d[I_UC];
		res.ov_led            = led_d[I_OV];
		res.uv_led            = led_d[I_UV];
		res.ot_led            = led_d[I_OT];
		res.fault_code        = fault_d;
		res.alarm_count       = alarm_d;
		res.clear_open_count  = clr_open;
		res.clear_xray_timers = clr_xray;
	end
endmodule
